[rtl/wildcard_star_regex_matcher_unit_macros.svh]
// Assertion macros shared by the wildcard star matcher RTL.
`ifndef WILDCARD_STAR_REGEX_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_STAR_REGEX_MATCHER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WSRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wsrm_pkg.sv]
// Types and constants shared by the wildcard star matcher modules.
package wsrm_pkg;

  typedef logic [7:0] sym_t;

  localparam sym_t WildcardByte = 8'd46;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeChar = 2'd1,
    ModeEnd  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    sym_t       symbol;
    logic       is_star;
    logic       first_token;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic first_token;
    sym_t symbol;
    logic is_star;
  } load_cmd_t;

endpackage

[rtl/wsrm_token_store.sv]
// Pattern token registers with fill mask and overflow flag.
module wsrm_token_store #(
  parameter int unsigned MAX_TOKENS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wsrm_pkg::load_cmd_t                 load_i,
  output wsrm_pkg::sym_t [MAX_TOKENS-1:0]     symbols_o,
  output logic [MAX_TOKENS-1:0]               starred_o,
  output logic [MAX_TOKENS-1:0]               valid_o,
  output logic                                overflow_o
);
  import wsrm_pkg::*;

  sym_t [MAX_TOKENS-1:0] symbols_q;
  logic [MAX_TOKENS-1:0] starred_q;
  logic [MAX_TOKENS-1:0] valid_q, valid_d;
  logic [MAX_TOKENS-1:0] base_valid, grown_valid, wr_sel;
  logic [MAX_TOKENS:0]   grown_ext;
  logic                  full;
  logic                  overflow_q, overflow_d;

  always_comb begin
    base_valid  = load_i.first_token ? '0 : valid_q;
    grown_ext   = {base_valid, 1'b1};
    grown_valid = grown_ext[MAX_TOKENS-1:0];
    full        = base_valid[MAX_TOKENS-1];
    wr_sel      = grown_valid & ~base_valid;
    valid_d     = valid_q;
    overflow_d  = overflow_q;
    if (load_i.load) begin
      valid_d    = grown_valid;
      overflow_d = (load_i.first_token ? 1'b0 : overflow_q) | full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      overflow_q <= overflow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < MAX_TOKENS; i++) begin
      if (load_i.load && wr_sel[i]) begin
        symbols_q[i] <= load_i.symbol;
        starred_q[i] <= load_i.is_star;
      end
    end
  end

  assign symbols_o  = symbols_q;
  assign starred_o  = starred_q;
  assign valid_o    = valid_q;
  assign overflow_o = overflow_q;

endmodule

[rtl/wsrm_nfa_step.sv]
// Closure over starred tokens and one-character advance of the active set.
module wsrm_nfa_step #(
  parameter int unsigned MAX_TOKENS = 32
) (
  input  logic [MAX_TOKENS:0]             active_i,
  input  wsrm_pkg::sym_t [MAX_TOKENS-1:0] symbols_i,
  input  logic [MAX_TOKENS-1:0]           starred_i,
  input  logic [MAX_TOKENS-1:0]           valid_i,
  input  wsrm_pkg::sym_t                  symbol_i,
  output logic [MAX_TOKENS:0]             next_o,
  output logic                            end_hit_o
);
  import wsrm_pkg::*;

  logic [MAX_TOKENS:0]   star_ext, gen, sum, carry, closed, end_sel;
  logic [MAX_TOKENS-1:0] hit;

  // A set position at a starred token spreads upwards through the run of
  // starred tokens, which is exactly a carry chain, so one adder closes it.
  always_comb begin
    star_ext = {1'b0, starred_i & valid_i};
    gen      = active_i & star_ext;
    sum      = gen + star_ext;
    carry    = sum ^ gen ^ star_ext;
    closed   = active_i | carry;
    for (int unsigned i = 0; i < MAX_TOKENS; i++) begin
      hit[i] = valid_i[i] & closed[i] &
               ((symbols_i[i] == WildcardByte) || (symbols_i[i] == symbol_i));
    end
    next_o    = {1'b0, hit & starred_i} | {hit & ~starred_i, 1'b0};
    end_sel   = {valid_i, 1'b1} & ~{1'b0, valid_i};
    end_hit_o = |(closed & end_sel);
  end

endmodule

[rtl/wildcard_star_regex_matcher_unit.sv]
// Top level of the wildcard star full-string pattern matcher.
//
// Usage: items arrive on the in channel (in_valid_i, in_stall_o, in_item_i).
// A load item appends one pattern token, and first_token starts a new pattern.
// A character item advances the set of active pattern positions by one byte.
// An end item yields one result item on the out channel (out_valid_o,
// out_stall_i, out_item_o) and restarts the subject against the same pattern.
// Each item is taken into an input register and processed from there by
// one adder-based closure and per-token compares, so one item is accepted in
// every cycle while no end item waits. The result of an end item is registered
// as it proceeds. Patterns beyond MAX_TOKENS tokens set overflow, and every
// result then reports no match until a new pattern is started.
// Reset clears the pattern and the overflow flag and activates position zero.
// While the receiver stalls, the result holds; character and load items keep
// flowing, and an end item waits in the input register, stalling the sender.
`include "wildcard_star_regex_matcher_unit_macros.svh"

module wildcard_star_regex_matcher_unit #(
  parameter int unsigned MAX_TOKENS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wsrm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wsrm_pkg::out_item_t out_item_o
);
  import wsrm_pkg::*;

  logic                  in_valid_q, in_valid_d;
  in_item_t              in_item_q;
  logic                  accept, proceed, is_end, out_free;
  logic [MAX_TOKENS:0]   active_q, active_d, nfa_next, pos_allowed;
  logic                  end_hit;
  load_cmd_t             load_cmd;
  sym_t [MAX_TOKENS-1:0] tok_symbols;
  logic [MAX_TOKENS-1:0] tok_starred, tok_valid;
  logic                  tok_overflow;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  assign is_end     = (in_item_q.mode == ModeEnd);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proceed    = in_valid_q && (!is_end || out_free);
  assign in_stall_o = in_valid_q && !proceed;
  assign accept     = in_valid_i && !in_stall_o;

  assign load_cmd.load        = proceed && (in_item_q.mode == ModeLoad);
  assign load_cmd.first_token = in_item_q.first_token;
  assign load_cmd.symbol      = in_item_q.symbol;
  assign load_cmd.is_star     = in_item_q.is_star;

  wsrm_token_store #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_token_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load_cmd),
    .symbols_o  (tok_symbols),
    .starred_o  (tok_starred),
    .valid_o    (tok_valid),
    .overflow_o (tok_overflow)
  );

  wsrm_nfa_step #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_nfa_step (
    .active_i  (active_q),
    .symbols_i (tok_symbols),
    .starred_i (tok_starred),
    .valid_i   (tok_valid),
    .symbol_i  (in_item_q.symbol),
    .next_o    (nfa_next),
    .end_hit_o (end_hit)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (proceed) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (proceed) begin
      unique case (in_item_q.mode)
        ModeLoad: begin
          active_d = (MAX_TOKENS + 1)'(1);
        end
        ModeChar: begin
          active_d = nfa_next;
        end
        ModeEnd: begin
          active_d            = (MAX_TOKENS + 1)'(1);
          out_valid_d         = 1'b1;
          out_item_d.matched  = end_hit && !tok_overflow;
          out_item_d.overflow = tok_overflow;
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      active_q    <= (MAX_TOKENS + 1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign pos_allowed = {tok_valid, 1'b1};

  `WSRM_ASSERT_NOW(a_active_in_range, 1'b1, (active_q & ~pos_allowed) == '0,
    "Active position lies beyond the stored pattern.")
  `WSRM_ASSERT_NEXT(a_end_gives_result, proceed && is_end, out_valid_q,
    "End item proceeded without raising a result.")
  `WSRM_ASSERT_NOW(a_overflow_no_match, out_valid_q && out_item_q.overflow,
    !out_item_q.matched, "Result reports a match despite overflow.")
  `WSRM_ASSERT_NEXT(a_held_item_kept, in_valid_q && !proceed, in_valid_q,
    "Waiting item left the input register without being processed.")

endmodule
